@@ design/pmcf_pkg.sv @@
// shared constants, types and helper functions for the pattern mask crossfade block
package pmcf_pkg;

	// pattern store geometry
	localparam int PATTERN_DEPTH = 16384;
	localparam int ADDR_W        = $clog2(PATTERN_DEPTH);

	// screen and pattern geometry
	localparam int MAX_LINE  = 1024;
	localparam int MAX_LINES = 1024;
	localparam int CNT_W     = 10;
	localparam int DIM_W     = CNT_W + 1;
	localparam int PROD_W    = DIM_W + CNT_W;

	// sample and phase widths
	localparam int PIX_W   = 8;
	localparam int PHASE_W = 8;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE          = 3'd4;

	// input mode codes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_BLEND = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		rgb_t after_rgb;
		rgb_t before_rgb;
		logic last;
	} pix_t;

	// zero acts as one, anything past the maximum acts as the maximum
	function automatic logic [DIM_W-1:0] size_of(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] max_v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// weighted mix of two samples, weight in 255ths, result divided by 256
	function automatic logic [PIX_W-1:0] mix(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] w);
		logic [PIX_W-1:0]   inv;
		logic [2*PIX_W-1:0] sum;
		inv = {PIX_W{1'b1}} - w;
		sum = ({{PIX_W{1'b0}}, a} * {{PIX_W{1'b0}}, w})
			+ ({{PIX_W{1'b0}}, b} * {{PIX_W{1'b0}}, inv});
		return sum[2*PIX_W-1:PIX_W];
	endfunction

endpackage

@@ design/pmcf_scan.sv @@
// raster scan counters and tiled pattern index generation
module pmcf_scan (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [pmcf_pkg::DIM_W-1:0]   sw,
	input  logic [pmcf_pkg::DIM_W-1:0]   sh,
	input  logic [pmcf_pkg::DIM_W-1:0]   pw,
	input  logic [pmcf_pkg::DIM_W-1:0]   ph,
	output logic [pmcf_pkg::ADDR_W-1:0]  index,
	output logic                         last
);

	logic [pmcf_pkg::CNT_W-1:0]  pcol_q, prow_q, scol_q, srow_q;
	logic [pmcf_pkg::DIM_W-1:0]  pcol_n, prow_n, scol_n, srow_n;
	logic [pmcf_pkg::PROD_W-1:0] row_base;
	logic                        pcol_wrap, prow_wrap, scol_wrap, srow_wrap;

	// pattern index for the current pixel, reduced to the store depth
	assign row_base = pw * prow_q;
	assign index    = row_base[pmcf_pkg::ADDR_W-1:0]
		+ pmcf_pkg::ADDR_W'(pcol_q);

	// next values and wrap tests
	assign pcol_n    = pmcf_pkg::DIM_W'(pcol_q) + pmcf_pkg::DIM_W'(1);
	assign prow_n    = pmcf_pkg::DIM_W'(prow_q) + pmcf_pkg::DIM_W'(1);
	assign scol_n    = pmcf_pkg::DIM_W'(scol_q) + pmcf_pkg::DIM_W'(1);
	assign srow_n    = pmcf_pkg::DIM_W'(srow_q) + pmcf_pkg::DIM_W'(1);
	assign pcol_wrap = pcol_n >= pw;
	assign prow_wrap = prow_n >= ph;
	assign scol_wrap = scol_n >= sw;
	assign srow_wrap = srow_n >= sh;
	assign last      = scol_wrap && srow_wrap;

	// counter update on every accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q <= '0;
			prow_q <= '0;
			scol_q <= '0;
			srow_q <= '0;
		end else if (step) begin
			if (scol_wrap) begin
				scol_q <= '0;
				pcol_q <= '0;
				if (srow_wrap) begin
					srow_q <= '0;
					prow_q <= '0;
				end else begin
					srow_q <= srow_n[pmcf_pkg::CNT_W-1:0];
					prow_q <= prow_wrap ? '0 : prow_n[pmcf_pkg::CNT_W-1:0];
				end
			end else begin
				scol_q <= scol_n[pmcf_pkg::CNT_W-1:0];
				pcol_q <= pcol_wrap ? '0 : pcol_n[pmcf_pkg::CNT_W-1:0];
			end
		end
	end

endmodule

@@ design/pmcf_store.sv @@
// single port pattern store with registered read data
module pmcf_store (
	input  logic                         clk,
	input  logic                         we,
	input  logic                         re,
	input  logic [pmcf_pkg::ADDR_W-1:0]  addr,
	input  logic [pmcf_pkg::PIX_W-1:0]   wdata,
	output logic [pmcf_pkg::PIX_W-1:0]   rdata
);

	logic [pmcf_pkg::PIX_W-1:0] mem [pmcf_pkg::PATTERN_DEPTH];

	// one access per cycle, write or read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ design/pmcf_blend.sv @@
// weight clamp stage and per channel blend into the output register
module pmcf_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pmcf_pkg::PIX_W-1:0]    pattern,
	input  pmcf_pkg::pix_t                px,
	input  logic [pmcf_pkg::PHASE_W-1:0]  phase,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pmcf_pkg::PIX_W-1:0]    out_red,
	output logic [pmcf_pkg::PIX_W-1:0]    out_green,
	output logic [pmcf_pkg::PIX_W-1:0]    out_blue,
	output logic                          frame_end
);

	logic                        v_s3;
	logic [pmcf_pkg::PIX_W-1:0]  w_s3;
	pmcf_pkg::pix_t              px_s3;
	logic                        out_valid_q;
	logic                        en_out, en_s3;
	logic [pmcf_pkg::PIX_W+1:0]  diff;
	logic [pmcf_pkg::PIX_W-1:0]  weight;

	// stage enables
	assign en_out   = !out_valid_q || out_ready;
	assign en_s3    = !v_s3 || en_out;
	assign in_ready = en_s3;

	// weight = clamp(2*phase - pattern, 0, 255)
	assign diff = {1'b0, phase, 1'b0} - {2'b00, pattern};
	always_comb begin
		if (diff[pmcf_pkg::PIX_W+1]) begin
			weight = '0;
		end else if (diff[pmcf_pkg::PIX_W]) begin
			weight = {pmcf_pkg::PIX_W{1'b1}};
		end else begin
			weight = diff[pmcf_pkg::PIX_W-1:0];
		end
	end

	// weight stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= in_valid;
		end
	end

	// weight stage payload
	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			w_s3  <= weight;
			px_s3 <= px;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s3;
		end
	end

	// blended samples
	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			out_red   <= pmcf_pkg::mix(px_s3.after_rgb.red, px_s3.before_rgb.red, w_s3);
			out_green <= pmcf_pkg::mix(px_s3.after_rgb.green, px_s3.before_rgb.green, w_s3);
			out_blue  <= pmcf_pkg::mix(px_s3.after_rgb.blue, px_s3.before_rgb.blue, w_s3);
			frame_end <= px_s3.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/pattern_mask_crossfade_top.sv @@
// top level of the pattern mask crossfade blender
//
// Input channel (in_valid/in_ready) takes two kinds of item. A load item
// (mode 0) writes pattern_value into the pattern store at pattern_addr and
// gives no result. A blend item (mode 1) carries before and after RGB samples
// of one pixel in raster order and gives one result on the output channel
// (out_valid/out_ready): the blended RGB and frame_end on the last pixel.
// The pattern is tiled over the screen by wrapping column and row counters.
// Sizes and phase are set through the write port (cfg_we, cfg_index,
// cfg_data); the user must do so only while no item is in flight, as the
// block does not enforce it. Throughput is one item per cycle unless the
// receiver stalls. A blend result passes the index, store read, weight and
// output registers. The store has one port, used by the item in the index
// register, so loads and reads stay in item order.
// Reset clears the counters, sizes (640x480 screen and pattern) and phase and
// empties the pipeline; store contents are undefined until loaded.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// input ready falls only once every stage holding a pixel is occupied.
module pattern_mask_crossfade_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [pmcf_pkg::ADDR_W-1:0]     pattern_addr,
	input  logic [pmcf_pkg::PIX_W-1:0]      pattern_value,
	input  logic [pmcf_pkg::PIX_W-1:0]      after_red,
	input  logic [pmcf_pkg::PIX_W-1:0]      after_green,
	input  logic [pmcf_pkg::PIX_W-1:0]      after_blue,
	input  logic [pmcf_pkg::PIX_W-1:0]      before_red,
	input  logic [pmcf_pkg::PIX_W-1:0]      before_green,
	input  logic [pmcf_pkg::PIX_W-1:0]      before_blue,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pmcf_pkg::PIX_W-1:0]      out_red,
	output logic [pmcf_pkg::PIX_W-1:0]      out_green,
	output logic [pmcf_pkg::PIX_W-1:0]      out_blue,
	output logic                            frame_end,
	input  logic                            cfg_we,
	input  logic [pmcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmcf_pkg::CFG_W-1:0]      cfg_data
);

	logic [pmcf_pkg::DIM_W-1:0]   sw_q, sh_q, pw_q, ph_q;
	logic [pmcf_pkg::PHASE_W-1:0] phase_q;
	logic [pmcf_pkg::DIM_W-1:0]   sw, sh, pw, ph;

	logic                         step, last;
	logic [pmcf_pkg::ADDR_W-1:0]  index;

	logic                         v_s1, pix_s1;
	logic [pmcf_pkg::ADDR_W-1:0]  addr_s1;
	logic [pmcf_pkg::PIX_W-1:0]   wdata_s1;
	pmcf_pkg::pix_t               px_s1;
	pmcf_pkg::pix_t               px_in;

	logic                         v_s2;
	pmcf_pkg::pix_t               px_s2;
	logic [pmcf_pkg::PIX_W-1:0]   rdata;

	logic                         blend_ready, en_s2, accept;
	logic                         st_we, st_re;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q    <= pmcf_pkg::DIM_W'(640);
			sh_q    <= pmcf_pkg::DIM_W'(480);
			pw_q    <= pmcf_pkg::DIM_W'(640);
			ph_q    <= pmcf_pkg::DIM_W'(480);
			phase_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pmcf_pkg::CFG_SCREEN_WIDTH:   sw_q <= cfg_data;
				pmcf_pkg::CFG_SCREEN_HEIGHT:  sh_q <= cfg_data;
				pmcf_pkg::CFG_PATTERN_WIDTH:  pw_q <= cfg_data;
				pmcf_pkg::CFG_PATTERN_HEIGHT: ph_q <= cfg_data;
				pmcf_pkg::CFG_PHASE:          phase_q <= cfg_data[pmcf_pkg::PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes
	assign sw = pmcf_pkg::size_of(sw_q, pmcf_pkg::DIM_W'(pmcf_pkg::MAX_LINE));
	assign sh = pmcf_pkg::size_of(sh_q, pmcf_pkg::DIM_W'(pmcf_pkg::MAX_LINES));
	assign pw = pmcf_pkg::size_of(pw_q, pmcf_pkg::DIM_W'(pmcf_pkg::MAX_LINE));
	assign ph = pmcf_pkg::size_of(ph_q, pmcf_pkg::DIM_W'(pmcf_pkg::MAX_LINES));

	// handshake and stage enables; a load leaves the index stage unconditionally
	assign en_s2    = !v_s2 || blend_ready;
	assign in_ready = !v_s1 || !pix_s1 || en_s2;
	assign accept   = in_valid && in_ready;
	assign step     = accept && (mode == pmcf_pkg::MODE_BLEND);

	pmcf_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sw     (sw),
		.sh     (sh),
		.pw     (pw),
		.ph     (ph),
		.index  (index),
		.last   (last)
	);

	// pixel payload of the incoming item
	assign px_in.after_rgb.red    = after_red;
	assign px_in.after_rgb.green  = after_green;
	assign px_in.after_rgb.blue   = after_blue;
	assign px_in.before_rgb.red   = before_red;
	assign px_in.before_rgb.green = before_green;
	assign px_in.before_rgb.blue  = before_blue;
	assign px_in.last             = last;

	// index stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// index stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= mode;
			addr_s1  <= (mode == pmcf_pkg::MODE_BLEND) ? index : pattern_addr;
			wdata_s1 <= pattern_value;
			px_s1    <= px_in;
		end
	end

	// store access from the index stage
	assign st_we = v_s1 && !pix_s1;
	assign st_re = v_s1 && pix_s1 && en_s2;

	pmcf_store u_store (
		.clk   (clk),
		.we    (st_we),
		.re    (st_re),
		.addr  (addr_s1),
		.wdata (wdata_s1),
		.rdata (rdata)
	);

	// read stage control, only pixels move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1 && pix_s1;
		end
	end

	// read stage payload, aligned with the store read data
	always_ff @(posedge clk) begin
		if (st_re) begin
			px_s2 <= px_s1;
		end
	end

	pmcf_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (blend_ready),
		.pattern   (rdata),
		.px        (px_s2),
		.phase     (phase_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.frame_end (frame_end)
	);

	// store port is never asked to write and read in one cycle
	a_store_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_we && st_re))
		else $error("pattern store written and read in the same cycle");

	// an empty index stage always takes an item
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with empty index stage");

	// a pixel in the read stage is not dropped while the weight stage is full
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !blend_ready) |=> v_s2)
		else $error("pixel lost from read stage");

	// a load item never advances the scan counters
	a_load_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == pmcf_pkg::MODE_LOAD) |-> !step)
		else $error("load item moved the scan counters");

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the pattern mask crossfade blender
module testbench;
	import pmcf_pkg::*;

	typedef struct {
		logic              mode;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  value;
		rgb_t              after_px;
		rgb_t              before_px;
	} in_item_t;

	typedef struct {
		rgb_t rgb;
		logic last;
	} blend_result_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

	// predicts blended pixels and checks them in order
	class crossfade_scoreboard;
		logic [CFG_W-1:0]   screen_w, screen_h, pat_w, pat_h;
		logic [PHASE_W-1:0] phase_val;
		logic [PIX_W-1:0]   pattern_mem [PATTERN_DEPTH];
		bit                 loaded [PATTERN_DEPTH];
		int unsigned        pat_col, pat_row, scr_col, scr_row;
		blend_result_t      expected_pixels [$];
		int                 errors;

		function new();
			screen_w  = 640;
			screen_h  = 480;
			pat_w     = 640;
			pat_h     = 480;
			phase_val = '0;
			pat_col   = 0;
			pat_row   = 0;
			scr_col   = 0;
			scr_row   = 0;
			errors    = 0;
			foreach (loaded[i]) loaded[i] = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_SCREEN_WIDTH:   screen_w = data;
				CFG_SCREEN_HEIGHT:  screen_h = data;
				CFG_PATTERN_WIDTH:  pat_w = data;
				CFG_PATTERN_HEIGHT: pat_h = data;
				CFG_PHASE:          phase_val = data[PHASE_W-1:0];
				default: ;
			endcase
		endfunction

		// zero acts as one, oversized acts as the maximum
		function int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned max_v);
			if (v == '0) return 1;
			return (v > max_v) ? max_v : int'(v);
		endfunction

		// store entry the next pixel will read
		function int unsigned read_index();
			return (clamp_size(pat_w, MAX_LINE) * pat_row + pat_col) % PATTERN_DEPTH;
		endfunction

		function logic [PIX_W-1:0] blend_channel(int unsigned a, int unsigned b,
			int unsigned w);
			int unsigned s;
			s = (a * w + b * (255 - w)) >> 8;
			return PIX_W'(s);
		endfunction

		function void note_item(in_item_t it);
			int unsigned   sw, sh, pw, ph, w;
			int            t;
			blend_result_t res;
			if (it.mode == MODE_LOAD) begin
				pattern_mem[it.addr % PATTERN_DEPTH] = it.value;
				loaded[it.addr % PATTERN_DEPTH] = 1'b1;
				return;
			end
			sw = clamp_size(screen_w, MAX_LINE);
			sh = clamp_size(screen_h, MAX_LINES);
			pw = clamp_size(pat_w, MAX_LINE);
			ph = clamp_size(pat_h, MAX_LINES);
			// weight is twice the phase minus the threshold, clamped
			t = 2 * int'(phase_val) - int'(pattern_mem[read_index()]);
			if (t < 0) t = 0;
			if (t > 255) t = 255;
			w = t;
			res.rgb.red   = blend_channel(it.after_px.red, it.before_px.red, w);
			res.rgb.green = blend_channel(it.after_px.green, it.before_px.green, w);
			res.rgb.blue  = blend_channel(it.after_px.blue, it.before_px.blue, w);
			res.last      = 1'b0;
			// raster counters, every wrap test is next >= size
			pat_col = (pat_col + 1 >= pw) ? 0 : pat_col + 1;
			if (scr_col + 1 >= sw) begin
				scr_col = 0;
				pat_col = 0;
				pat_row = (pat_row + 1 >= ph) ? 0 : pat_row + 1;
				if (scr_row + 1 >= sh) begin
					res.last = 1'b1;
					scr_row  = 0;
					pat_row  = 0;
				end else begin
					scr_row = scr_row + 1;
				end
			end else begin
				scr_col = scr_col + 1;
			end
			expected_pixels.push_back(res);
		endfunction

		function void compare_field(string name, int e, int a);
			if (e != a) begin
				$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_pixel(blend_result_t got);
			blend_result_t want;
			if (expected_pixels.size() == 0) begin
				$display("%0t unexpected pixel: expected none, actual r %0d g %0d b %0d last %0d",
					$time, got.rgb.red, got.rgb.green, got.rgb.blue, got.last);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("out_red", want.rgb.red, got.rgb.red);
			compare_field("out_green", want.rgb.green, got.rgb.green);
			compare_field("out_blue", want.rgb.blue, got.rgb.blue);
			compare_field("frame_end", want.last, got.last);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [ADDR_W-1:0]    pattern_addr;
	logic [PIX_W-1:0]     pattern_value;
	logic [PIX_W-1:0]     after_red, after_green, after_blue;
	logic [PIX_W-1:0]     before_red, before_green, before_blue;
	logic                 out_valid;
	logic                 out_ready;
	logic [PIX_W-1:0]     out_red, out_green, out_blue;
	logic                 frame_end;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	crossfade_scoreboard sb;
	idle_t               idle_mode = IDLE_NONE;

	pattern_mask_crossfade_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.pattern_addr (pattern_addr),
		.pattern_value(pattern_value),
		.after_red    (after_red),
		.after_green  (after_green),
		.after_blue   (after_blue),
		.before_red   (before_red),
		.before_green (before_green),
		.before_blue  (before_blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.frame_end    (frame_end),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit sender_gap();
		int pct;
		pct = (idle_mode == IDLE_SENDER) ? 57 : (idle_mode == IDLE_BOTH) ? 9 : 0;
		return $urandom_range(99) < pct;
	endfunction

	function automatic int receiver_stall_pct();
		return (idle_mode == IDLE_RECEIVER) ? 57 : (idle_mode == IDLE_BOTH) ? 9 : 0;
	endfunction

	// sample value leaning toward the extremes
	function automatic logic [PIX_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic rgb_t rand_rgb();
		rgb_t c;
		c.red   = rand_sample();
		c.green = rand_sample();
		c.blue  = rand_sample();
		return c;
	endfunction

	// size register value: mostly small, sometimes zero, maximum or oversized
	function automatic logic [CFG_W-1:0] rand_size(int unsigned lo, int unsigned hi);
		case ($urandom_range(9))
			0: return '0;
			1: return CFG_W'(1);
			2: return CFG_W'(MAX_LINE);
			3: return '1;
			4: return CFG_W'($urandom_range(MAX_LINE + 1, 2047));
			default: return CFG_W'($urandom_range(lo, hi));
		endcase
	endfunction

	// present one item at the falling edge, hold it until accepted
	task automatic send_item(input in_item_t it);
		while (sender_gap()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid      = 1'b1;
		mode          = it.mode;
		pattern_addr  = it.addr;
		pattern_value = it.value;
		after_red     = it.after_px.red;
		after_green   = it.after_px.green;
		after_blue    = it.after_px.blue;
		before_red    = it.before_px.red;
		before_green  = it.before_px.green;
		before_blue   = it.before_px.blue;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_load(input logic [ADDR_W-1:0] addr, input logic [PIX_W-1:0] value);
		in_item_t it;
		it.mode      = MODE_LOAD;
		it.addr      = addr;
		it.value     = value;
		it.after_px  = rand_rgb();
		it.before_px = rand_rgb();
		send_item(it);
	endtask

	// a pixel never reads a store entry that was not loaded
	task automatic send_pixel(input rgb_t after_px, input rgb_t before_px);
		in_item_t it;
		if (!sb.loaded[sb.read_index()])
			send_load(ADDR_W'(sb.read_index()), rand_sample());
		it.mode      = MODE_BLEND;
		it.addr      = ADDR_W'($urandom);
		it.value     = PIX_W'($urandom);
		it.after_px  = after_px;
		it.before_px = before_px;
		send_item(it);
	endtask

	// stop sending until every expected pixel has come out
	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// write the selected registers once the pipeline is empty
	task automatic set_config(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
		input logic [CFG_W-1:0] pw, input logic [CFG_W-1:0] ph,
		input logic [PHASE_W-1:0] phv, input logic [4:0] which);
		wait_drained();
		repeat (6) @(negedge clk);
		if (which[0]) write_reg(CFG_SCREEN_WIDTH, sw);
		if (which[1]) write_reg(CFG_SCREEN_HEIGHT, sh);
		if (which[2]) write_reg(CFG_PATTERN_WIDTH, pw);
		if (which[3]) write_reg(CFG_PATTERN_HEIGHT, ph);
		if (which[4]) write_reg(CFG_PHASE, {3'($urandom), phv});
		cfg_we = 1'b0;
	endtask

	// receiver: stall at the falling edge, take results at the rising edge
	initial begin
		blend_result_t got;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready = (receiver_stall_pct() == 0) || ($urandom_range(99) >= receiver_stall_pct());
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.rgb.red   = out_red;
				got.rgb.green = out_green;
				got.rgb.blue  = out_blue;
				got.last      = frame_end;
				sb.check_pixel(got);
			end
		end
	end

	// stimulus
	initial begin
		logic [CFG_W-1:0]   sw, sh, pw, ph;
		logic [PHASE_W-1:0] phv;
		logic [4:0]         which;
		sb            = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = MODE_LOAD;
		pattern_addr  = '0;
		pattern_value = '0;
		after_red     = '0;
		after_green   = '0;
		after_blue    = '0;
		before_red    = '0;
		before_green  = '0;
		before_blue   = '0;
		out_ready     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SCREEN_WIDTH;
		cfg_data      = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: one small frame with thresholds at both ends
		set_config(11'd4, 11'd2, 11'd3, 11'd2, 8'd255, 5'b11111);
		send_load(14'd0, 8'd0);
		send_load(14'd1, 8'd255);
		send_load(14'd2, 8'd128);
		send_load(14'd3, 8'd1);
		send_load(14'd4, 8'd254);
		send_load(14'd5, 8'd200);
		send_load(14'h3fff, 8'haa);
		send_pixel(24'hffffff, 24'h000000);
		send_pixel(24'h000000, 24'hffffff);
		send_pixel(24'hffffff, 24'hffffff);
		send_pixel(24'h000000, 24'h000000);
		send_pixel(24'h807f01, 24'hfe02ff);
		repeat (3) send_pixel(rand_rgb(), rand_rgb());
		// phase zero: weight clamps at zero
		set_config('0, '0, '0, '0, 8'd0, 5'b10000);
		send_pixel(24'hffffff, 24'h000000);
		send_pixel(24'h000000, 24'hffffff);
		repeat (2) send_pixel(rand_rgb(), rand_rgb());
		// zero screen width acts as one, mid-frame size change
		set_config('0, '0, '0, '0, 8'd128, 5'b10001);
		send_pixel(24'hffffff, 24'h000000);
		repeat (3) send_pixel(rand_rgb(), rand_rgb());

		// random phases, each with its own setting and idling
		for (int p = 0; p < 12; p++) begin
			case (p)
				0: begin
					// one pixel per line, wide pattern: read index wraps the store
					sw = '0; sh = '1; pw = '1; ph = CFG_W'(MAX_LINES); phv = 8'd200;
				end
				1: begin
					sw = CFG_W'(MAX_LINE); sh = 11'd1; pw = 11'd1; ph = '0; phv = 8'd0;
				end
				2: begin
					sw = 11'd5; sh = 11'd3; pw = 11'd7; ph = 11'd2; phv = 8'd255;
				end
				default: begin
					sw = rand_size(2, 12);
					sh = rand_size(1, 6);
					pw = rand_size(2, 40);
					ph = rand_size(2, 40);
					case ($urandom_range(4))
						0: phv = '0;
						1: phv = '1;
						default: phv = PHASE_W'($urandom);
					endcase
				end
			endcase
			which = (p < 3) ? 5'b11111 : 5'($urandom_range(1, 31));
			set_config(sw, sh, pw, ph, phv, which);
			idle_mode = idle_t'(p % 4);
			for (int k = 0; k < 100; k++) begin
				if (k == 50) wait_drained();
				if ($urandom_range(99) < 20) begin
					// loads often hit the entry about to be read
					if ($urandom_range(1) == 1)
						send_load(ADDR_W'(sb.read_index()), rand_sample());
					else
						send_load(ADDR_W'($urandom), rand_sample());
				end else begin
					send_pixel(rand_rgb(), rand_rgb());
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
			$display("** pattern_mask_crossfade_top: PASSED **");
		end else begin
			$display("** pattern_mask_crossfade_top: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("** pattern_mask_crossfade_top: FAILED **");
		$finish;
	end

endmodule
